FILE: rtl/core/hashed_page_slot_cache_defines.svh
// ----------------------------------------------------------------------------
// Page slot cache assertion macros
// Shared assertion forms for the page slot cache RTL. Each macro samples on
// clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HASHED_PAGE_SLOT_CACHE_DEFINES_SVH
`define HASHED_PAGE_SLOT_CACHE_DEFINES_SVH

// A condition that holds at every clock edge.
`define HPSC_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another at the same clock edge.
`define HPSC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another at the next clock edge.
`define HPSC_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hpsc_pkg.sv
// ----------------------------------------------------------------------------
// Page slot cache package
// Transfer payload types, request and status codes and default sizes.
// ----------------------------------------------------------------------------
package hpsc_pkg;

  localparam int MAX_SLOTS_DEF    = 1024;
  localparam int HASH_BUCKETS_DEF = 256;

  localparam int REQ_W       = 2;
  localparam int PAGE_KEY_W  = 32;
  localparam int SLOT_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int MAX_PAGES_W = 11;

  localparam logic [MAX_PAGES_W-1:0] MAX_PAGES_RST = 11'd1024;

  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNPIN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNPIN_ERR = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [PAGE_KEY_W-1:0] page_key;
    logic [SLOT_W-1:0]     slot_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } out_item_t;

endpackage

FILE: rtl/core/hashed_page_slot_cache.sv
// ----------------------------------------------------------------------------
// Hashed page slot cache
// A request transfer is taken when start is high and busy is low; busy then
// stays high until the result is out. Each request gives exactly one result,
// shown on out_data for a single cycle with out_valid high, and the receiver
// cannot stall it. The bucket hash runs on a shared multiplier, then the
// chain walk visits one slot per cycle through the slot key and link
// memories. A get walks its bucket's chain until a key matches or the chain
// ends; a fetch that misses then goes on to allocate a slot or report full.
// An unpin first reads the pin flag and key of its slot, then hashes that
// key and walks the chain to the slot; an unpin of a slot that is out of
// range or not pinned answers with an error without a hash.
// A request of an unused type answers in the next cycle without busy. After
// reset a clearing pass over max(MAX_SLOTS, HASH_BUCKETS) entries empties the
// buckets and pin flags with busy high; configuration writes are taken
// throughout.
// ----------------------------------------------------------------------------
`include "hashed_page_slot_cache_defines.svh"

module hashed_page_slot_cache import hpsc_pkg::*; #(
  parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
  parameter int HASH_BUCKETS = HASH_BUCKETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [MAX_PAGES_W-1:0] cfg_wdata
);

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int LW    = $clog2(MAX_SLOTS + 1);
  localparam int BW    = $clog2(HASH_BUCKETS);
  localparam int CW    = (LW > MAX_PAGES_W) ? LW : MAX_PAGES_W;
  localparam int CLR_N = (MAX_SLOTS > HASH_BUCKETS) ? MAX_SLOTS : HASH_BUCKETS;
  localparam int CLW   = $clog2(CLR_N);
  localparam logic [LW-1:0] LINK_NONE = LW'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPIN, S_UCHK, S_HASH, S_STEP, S_ALLOC
  } state_t;

  state_t                 state_r, state_nxt;
  logic [REQ_W-1:0]       mode_r, mode_nxt;
  logic [PAGE_KEY_W-1:0]  key_r, key_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic                   first_r, first_nxt;
  logic [LW-1:0]          idx_next_r, idx_next_nxt;
  logic [LW-1:0]          free_top_r, free_top_nxt;
  logic [LW-1:0]          pinned_cnt_r, pinned_cnt_nxt;
  logic [LW-1:0]          issued_r, issued_nxt;
  logic [MAX_PAGES_W-1:0] max_pages_r;
  logic [CLW-1:0]         clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                  hash_go;
  logic [PAGE_KEY_W-1:0] hash_key;
  logic                  hash_done;
  logic [BW-1:0]         hash_bucket;

  logic [LW-1:0]         head_rd_r;
  logic [PAGE_KEY_W-1:0] key_rd_r;
  logic [LW-1:0]         next_rd_r;
  logic                  pin_rd_r;
  logic [LW-1:0]         flink_rd_r;

  logic                  bh_we;
  logic [BW-1:0]         bh_wa;
  logic [LW-1:0]         bh_wd;
  logic                  sk_we;
  logic [SW-1:0]         sk_wa;
  logic                  cn_we;
  logic [SW-1:0]         cn_wa;
  logic [LW-1:0]         cn_wd;
  logic                  pn_we;
  logic [SW-1:0]         pn_wa;
  logic                  pn_wd;
  logic                  fl_we;

  logic [SW-1:0]         idx_s;
  logic [SW-1:0]         slot_ra;
  logic [LW-1:0]         cur_c;
  logic                  cur_end;
  logic                  cur_is_idx;
  logic                  idx_ok;
  logic                  can_fresh;
  logic                  alloc_ok;
  logic [SW-1:0]         alloc_s;

  logic [LW-1:0]         bh_mem [HASH_BUCKETS];
  logic [PAGE_KEY_W-1:0] sk_mem [MAX_SLOTS];
  logic [LW-1:0]         cn_mem [MAX_SLOTS];
  logic                  pn_mem [MAX_SLOTS];
  logic [LW-1:0]         fl_mem [MAX_SLOTS];

  hpsc_hash #(
    .HASH_BUCKETS (HASH_BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (hash_go),
    .key    (hash_key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  assign busy       = (state_r != S_IDLE);
  assign idx_s      = SW'(idx_r);
  assign cur_c      = first_r ? head_rd_r : next_rd_r;
  assign cur_end    = (cur_c >= LINK_NONE);
  assign cur_is_idx = !cur_end && (cur_c == LW'(idx_s));
  assign slot_ra    = (state_r == S_STEP) ? SW'(cur_c) : idx_s;
  assign idx_ok     = (32'(idx_r) < 32'(MAX_SLOTS));
  assign can_fresh  = (CW'(pinned_cnt_r) < CW'(max_pages_r)) && (issued_r < LINK_NONE);
  assign alloc_ok   = (free_top_r < LINK_NONE) || can_fresh;
  assign alloc_s    = (free_top_r < LINK_NONE) ? SW'(free_top_r) : SW'(issued_r);

  always_ff @(posedge clk) begin
    if (bh_we) begin
      bh_mem[bh_wa] <= bh_wd;
    end
    head_rd_r <= bh_mem[hash_bucket];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      sk_mem[sk_wa] <= key_r;
    end
    key_rd_r <= sk_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (cn_we) begin
      cn_mem[cn_wa] <= cn_wd;
    end
    next_rd_r <= cn_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (pn_we) begin
      pn_mem[pn_wa] <= pn_wd;
    end
    pin_rd_r <= pn_mem[idx_s];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[idx_s] <= free_top_r;
    end
    flink_rd_r <= fl_mem[SW'(free_top_r)];
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    first_nxt      = first_r;
    idx_next_nxt   = idx_next_r;
    free_top_nxt   = free_top_r;
    pinned_cnt_nxt = pinned_cnt_r;
    issued_nxt     = issued_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    hash_go        = 1'b0;
    hash_key       = in_data.page_key;
    bh_we          = 1'b0;
    bh_wa          = hash_bucket;
    bh_wd          = LINK_NONE;
    sk_we          = 1'b0;
    sk_wa          = alloc_s;
    cn_we          = 1'b0;
    cn_wa          = alloc_s;
    cn_wd          = head_rd_r;
    pn_we          = 1'b0;
    pn_wa          = idx_s;
    pn_wd          = 1'b0;
    fl_we          = 1'b0;

    case (state_r)
      S_CLEAR: begin
        bh_we = (32'(clr_r) < 32'(HASH_BUCKETS));
        bh_wa = BW'(clr_r);
        pn_we = (32'(clr_r) < 32'(MAX_SLOTS));
        pn_wa = SW'(clr_r);
        if (clr_r == CLW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + CLW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_data.req_type;
          key_nxt  = in_data.page_key;
          idx_nxt  = in_data.slot_index;
          case (in_data.req_type)
            REQ_GET, REQ_FETCH: begin
              hash_go   = 1'b1;
              state_nxt = S_HASH;
            end
            REQ_UNPIN: begin
              state_nxt = S_UPIN;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_MISS;
              out_data_nxt.slot   = '0;
            end
          endcase
        end
      end
      S_UPIN: begin
        state_nxt = S_UCHK;
      end
      S_UCHK: begin
        idx_next_nxt = next_rd_r;
        if (idx_ok && pin_rd_r) begin
          hash_go   = 1'b1;
          hash_key  = key_rd_r;
          state_nxt = S_HASH;
        end else begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_UNPIN_ERR;
          out_data_nxt.slot   = '0;
          state_nxt           = S_IDLE;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          first_nxt = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (mode_r == REQ_UNPIN) begin
          if (cur_end || cur_is_idx) begin
            if (cur_is_idx) begin
              if (first_r) begin
                bh_we = 1'b1;
                bh_wd = idx_next_r;
              end else begin
                cn_we = 1'b1;
                cn_wa = SW'(cur_r);
                cn_wd = idx_next_r;
              end
            end
            pn_we        = 1'b1;
            pn_wd        = 1'b0;
            fl_we        = 1'b1;
            free_top_nxt = LW'(idx_s);
            if (pinned_cnt_r != '0) begin
              pinned_cnt_nxt = pinned_cnt_r - LW'(1);
            end
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_HIT;
            out_data_nxt.slot   = idx_r;
            state_nxt           = S_IDLE;
          end else begin
            cur_nxt   = cur_c;
            first_nxt = 1'b0;
          end
        end else begin
          if (!first_r && (key_rd_r == key_r)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_HIT;
            out_data_nxt.slot   = SLOT_W'(cur_r);
            state_nxt           = S_IDLE;
          end else if (cur_end) begin
            if (mode_r == REQ_FETCH) begin
              state_nxt = S_ALLOC;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_MISS;
              out_data_nxt.slot   = '0;
              state_nxt           = S_IDLE;
            end
          end else begin
            cur_nxt   = cur_c;
            first_nxt = 1'b0;
          end
        end
      end
      S_ALLOC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (alloc_ok) begin
          if (free_top_r < LINK_NONE) begin
            free_top_nxt = flink_rd_r;
          end else begin
            issued_nxt = issued_r + LW'(1);
          end
          sk_we               = 1'b1;
          cn_we               = 1'b1;
          bh_we               = 1'b1;
          bh_wd               = LW'(alloc_s);
          pn_we               = 1'b1;
          pn_wa               = alloc_s;
          pn_wd               = 1'b1;
          pinned_cnt_nxt      = pinned_cnt_r + LW'(1);
          out_data_nxt.status = ST_NEW;
          out_data_nxt.slot   = SLOT_W'(alloc_s);
        end else begin
          out_data_nxt.status = ST_FULL;
          out_data_nxt.slot   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      free_top_r   <= LINK_NONE;
      pinned_cnt_r <= '0;
      issued_r     <= '0;
      max_pages_r  <= MAX_PAGES_RST;
      out_valid_r  <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      free_top_r   <= free_top_nxt;
      pinned_cnt_r <= pinned_cnt_nxt;
      issued_r     <= issued_nxt;
      out_valid_r  <= out_valid_nxt;
      first_r      <= first_nxt;
      if (cfg_we) begin
        max_pages_r <= cfg_wdata;
      end
    end
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    idx_next_r <= idx_next_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HPSC_ALWAYS(a_pinned_le_issued, pinned_cnt_r <= issued_r, "Pinned count exceeds issued slots.")
  `HPSC_ALWAYS(a_free_top_range, free_top_r <= LINK_NONE, "Free stack top is out of range.")
  `HPSC_IMPLY(a_result_when_free, out_valid_r, !busy, "Result shown while a request is in work.")
  `HPSC_IMPLY_NEXT(a_accept_acts, start && !busy, out_valid_r || busy, "Accepted request had no effect.")

endmodule

FILE: rtl/core/hpsc_hash.sv
// ----------------------------------------------------------------------------
// Page slot cache bucket hash
// Reduces a page key modulo the bucket count with one shared multiplier:
// a reciprocal multiply, a multiply back by the bucket count and a single
// compare and subtract correction.
// ----------------------------------------------------------------------------
module hpsc_hash import hpsc_pkg::*; #(
  parameter int HASH_BUCKETS = HASH_BUCKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [PAGE_KEY_W-1:0]           key,
  output logic                            done,
  output logic [$clog2(HASH_BUCKETS)-1:0] bucket
);

  localparam int BW  = $clog2(HASH_BUCKETS);
  localparam int HSH = PAGE_KEY_W + BW;
  localparam int MW  = PAGE_KEY_W + 1;
  localparam int PW  = MW + PAGE_KEY_W;
  localparam logic [63:0]           RECIP_W = (64'd1 << HSH) / 64'(HASH_BUCKETS);
  localparam logic [MW-1:0]         RECIP   = RECIP_W[MW-1:0];
  localparam logic [MW-1:0]         NB_M    = MW'(HASH_BUCKETS);
  localparam logic [PAGE_KEY_W-1:0] NB_K    = PAGE_KEY_W'(HASH_BUCKETS);

  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_QB, PH_RED} phase_t;

  phase_t                ph_r;
  logic [PAGE_KEY_W-1:0] key_r;
  logic [PW-1:0]         prod_r;
  logic [BW-1:0]         bucket_r;
  logic                  done_r;

  logic [PAGE_KEY_W-1:0] mul_a;
  logic [MW-1:0]         mul_b;
  logic [PW-1:0]         mul_p;
  logic [PAGE_KEY_W-1:0] quot;
  logic [PAGE_KEY_W-1:0] diff;
  logic [PAGE_KEY_W-1:0] red;

  assign quot  = PAGE_KEY_W'(prod_r >> HSH);
  assign mul_a = (ph_r == PH_MUL) ? key_r : quot;
  assign mul_b = (ph_r == PH_MUL) ? RECIP : NB_M;
  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign diff  = key_r - prod_r[PAGE_KEY_W-1:0];
  assign red   = (diff >= NB_K) ? (diff - NB_K) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (go) begin
            key_r <= key;
            ph_r  <= PH_MUL;
          end
        end
        PH_MUL: begin
          prod_r <= mul_p;
          ph_r   <= PH_QB;
        end
        PH_QB: begin
          prod_r <= mul_p;
          ph_r   <= PH_RED;
        end
        PH_RED: begin
          bucket_r <= BW'(red);
          done_r   <= 1'b1;
          ph_r     <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule
